// ===== design/pts_pkg.sv =====
`default_nettype none

package pts_pkg;

    // field widths
    localparam int unsigned ANGLE_W = 24;
    localparam int unsigned ERR_W   = 25;
    localparam int unsigned DERIV_W = 26;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned BAND_W  = 23;
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned SUM_W   = 40;
    localparam int unsigned PCT_W   = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // integral split for the two partial products
    localparam int unsigned SUM_LO_W = 20;
    localparam int unsigned SUM_HI_W = SUM_W - SUM_LO_W;

    // product and total widths
    localparam int unsigned PP_W    = GAIN_W + 1 + ERR_W;
    localparam int unsigned PD_W    = GAIN_W + 1 + DERIV_W;
    localparam int unsigned PIL_W   = GAIN_W + 1 + SUM_LO_W + 1;
    localparam int unsigned PIH_W   = GAIN_W + 1 + SUM_HI_W;
    localparam int unsigned TOTAL_W = 58;
    localparam int unsigned SCALE_SH = 16;
    localparam int unsigned QUOT_W  = TOTAL_W - SCALE_SH;

    // integral saturation bounds
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // input mode codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_RUN     = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd6;

    // register reset values
    localparam logic [ANGLE_W-1:0] RST_TARGET  = 24'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P  = 16'd256;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I  = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D  = 16'd256;
    localparam logic [BAND_W-1:0]  RST_BAND    = 23'd256;
    localparam logic [LIMIT_W-1:0] RST_LIMIT   = 7'd100;
    localparam logic [TICK_W-1:0]  RST_TIMEOUT = 16'd300;

    typedef struct packed {
        logic [ANGLE_W-1:0] target_angle;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [BAND_W-1:0]  integrate_band;
        logic [LIMIT_W-1:0] speed_limit;
        logic [TICK_W-1:0]  timeout_ticks;
    } t_cfg;

    // after the state update
    typedef struct packed {
        logic [1:0]         kind;
        logic [ERR_W-1:0]   err;
        logic [DERIV_W-1:0] deriv;
        logic [SUM_W-1:0]   sum;
    } t_s1;

    // after the multipliers
    typedef struct packed {
        logic [1:0]       kind;
        logic [ERR_W-1:0] err;
        logic [PP_W-1:0]  pp;
        logic [PD_W-1:0]  pd;
        logic [PIL_W-1:0] pil;
        logic [PIH_W-1:0] pih;
    } t_s2;

    // after the final sum
    typedef struct packed {
        logic [1:0]         kind;
        logic [ERR_W-1:0]   err;
        logic [TOTAL_W-1:0] total;
    } t_s3;

endpackage

`default_nettype wire

// ===== design/pts_cfg.sv =====
`default_nettype none

module pts_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output pts_pkg::t_cfg                        o_cfg
);

    pts_pkg::t_cfg r_cfg;

    // write one register per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_angle   <= pts_pkg::RST_TARGET;
            r_cfg.gain_p         <= pts_pkg::RST_GAIN_P;
            r_cfg.gain_i         <= pts_pkg::RST_GAIN_I;
            r_cfg.gain_d         <= pts_pkg::RST_GAIN_D;
            r_cfg.integrate_band <= pts_pkg::RST_BAND;
            r_cfg.speed_limit    <= pts_pkg::RST_LIMIT;
            r_cfg.timeout_ticks  <= pts_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pts_pkg::CFG_TARGET:  r_cfg.target_angle <= i_cfg_data;
                pts_pkg::CFG_GAIN_P:  r_cfg.gain_p <= i_cfg_data[pts_pkg::GAIN_W-1:0];
                pts_pkg::CFG_GAIN_I:  r_cfg.gain_i <= i_cfg_data[pts_pkg::GAIN_W-1:0];
                pts_pkg::CFG_GAIN_D:  r_cfg.gain_d <= i_cfg_data[pts_pkg::GAIN_W-1:0];
                pts_pkg::CFG_BAND:
                    r_cfg.integrate_band <= i_cfg_data[pts_pkg::BAND_W-1:0];
                pts_pkg::CFG_LIMIT:
                    r_cfg.speed_limit <= i_cfg_data[pts_pkg::LIMIT_W-1:0];
                pts_pkg::CFG_TIMEOUT:
                    r_cfg.timeout_ticks <= i_cfg_data[pts_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/pts_track.sv =====
`default_nettype none

module pts_track (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_accept,
    input  wire logic                           i_mode,
    input  wire logic [pts_pkg::ANGLE_W-1:0]    i_measured_angle,
    input  pts_pkg::t_cfg                       i_cfg,
    output pts_pkg::t_s1                        o_s1
);

    logic [pts_pkg::ERR_W-1:0]   r_last_error;
    logic [pts_pkg::SUM_W-1:0]   r_error_sum;
    logic [pts_pkg::TICK_W-1:0]  r_tick_count;
    pts_pkg::t_s1                r_s1;

    logic [pts_pkg::ERR_W-1:0]   w_target;
    logic [pts_pkg::ERR_W-1:0]   w_meas;
    logic [pts_pkg::ERR_W-1:0]   w_err;
    logic [pts_pkg::ERR_W-1:0]   w_mag;
    logic                        w_in_band;
    logic [pts_pkg::DERIV_W-1:0] w_deriv;
    logic [pts_pkg::SUM_W-1:0]   w_base;
    logic [pts_pkg::SUM_W:0]     w_acc;
    logic [pts_pkg::SUM_W-1:0]   w_sat;
    logic [pts_pkg::SUM_W-1:0]   n_error_sum;
    logic                        w_timed;

    // error, derivative and the conditional integral
    always_comb begin
        w_target = {i_cfg.target_angle[pts_pkg::ANGLE_W-1], i_cfg.target_angle};
        w_meas   = {i_measured_angle[pts_pkg::ANGLE_W-1], i_measured_angle};
        w_err    = w_target - w_meas;
        w_mag    = w_err[pts_pkg::ERR_W-1] ? (pts_pkg::ERR_W'(0) - w_err) : w_err;
        w_in_band = w_mag < {2'b00, i_cfg.integrate_band};
        w_deriv  = {w_err[pts_pkg::ERR_W-1], w_err}
                 - {r_last_error[pts_pkg::ERR_W-1], r_last_error};
        // clear the integral on a sign change
        w_base = (w_err[pts_pkg::ERR_W-1] != r_last_error[pts_pkg::ERR_W-1])
               ? '0 : r_error_sum;
        w_acc = {w_base[pts_pkg::SUM_W-1], w_base}
              + {{(pts_pkg::SUM_W + 1 - pts_pkg::ERR_W){w_err[pts_pkg::ERR_W-1]}}, w_err};
        if (w_acc[pts_pkg::SUM_W] != w_acc[pts_pkg::SUM_W-1]) begin
            w_sat = w_acc[pts_pkg::SUM_W] ? pts_pkg::SUM_MIN : pts_pkg::SUM_MAX;
        end else begin
            w_sat = w_acc[pts_pkg::SUM_W-1:0];
        end
        n_error_sum = w_in_band ? w_sat : w_base;
        w_timed = r_tick_count >= i_cfg.timeout_ticks;
    end

    // update the loop state on each accepted word, unless a tick word finds the timeout reached
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_error_sum  <= '0;
            r_tick_count <= '0;
        end else if (i_accept) begin
            if (i_mode == pts_pkg::MODE_START) begin
                r_last_error <= w_target;
                r_error_sum  <= '0;
                r_tick_count <= '0;
            end else if (!w_timed) begin
                r_last_error <= w_err;
                r_error_sum  <= n_error_sum;
                r_tick_count <= r_tick_count + pts_pkg::TICK_W'(1);
            end
        end
    end

    // capture the stage word
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1.deriv <= w_deriv;
            r_s1.sum   <= n_error_sum;
            if (i_mode == pts_pkg::MODE_START) begin
                r_s1.kind <= pts_pkg::KIND_START;
                r_s1.err  <= w_target;
            end else if (w_timed) begin
                r_s1.kind <= pts_pkg::KIND_EXPIRED;
                r_s1.err  <= w_err;
            end else begin
                r_s1.kind <= pts_pkg::KIND_RUN;
                r_s1.err  <= w_err;
            end
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

// ===== design/pts_mul.sv =====
`default_nettype none

module pts_mul (
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  pts_pkg::t_s1  i_s1,
    input  pts_pkg::t_cfg i_cfg,
    output pts_pkg::t_s2  o_s2
);

    pts_pkg::t_s2 r_s2;

    logic signed [pts_pkg::GAIN_W:0]     w_gp;
    logic signed [pts_pkg::GAIN_W:0]     w_gi;
    logic signed [pts_pkg::GAIN_W:0]     w_gd;
    logic signed [pts_pkg::ERR_W-1:0]    w_err;
    logic signed [pts_pkg::DERIV_W-1:0]  w_deriv;
    logic signed [pts_pkg::SUM_LO_W:0]   w_sum_lo;
    logic signed [pts_pkg::SUM_HI_W-1:0] w_sum_hi;
    logic signed [pts_pkg::PP_W-1:0]     w_pp;
    logic signed [pts_pkg::PD_W-1:0]     w_pd;
    logic signed [pts_pkg::PIL_W-1:0]    w_pil;
    logic signed [pts_pkg::PIH_W-1:0]    w_pih;

    // four products; the integral term is split into low and high halves
    always_comb begin
        w_gp     = $signed({1'b0, i_cfg.gain_p});
        w_gi     = $signed({1'b0, i_cfg.gain_i});
        w_gd     = $signed({1'b0, i_cfg.gain_d});
        w_err    = $signed(i_s1.err);
        w_deriv  = $signed(i_s1.deriv);
        w_sum_lo = $signed({1'b0, i_s1.sum[pts_pkg::SUM_LO_W-1:0]});
        w_sum_hi = $signed(i_s1.sum[pts_pkg::SUM_W-1:pts_pkg::SUM_LO_W]);
        w_pp     = w_gp * w_err;
        w_pd     = w_gd * w_deriv;
        w_pil    = w_gi * w_sum_lo;
        w_pih    = w_gi * w_sum_hi;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2.kind <= i_s1.kind;
            r_s2.err  <= i_s1.err;
            r_s2.pp   <= w_pp;
            r_s2.pd   <= w_pd;
            r_s2.pil  <= w_pil;
            r_s2.pih  <= w_pih;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

// ===== design/pts_drive.sv =====
`default_nettype none

module pts_drive (
    input  wire logic                       i_clk,
    input  wire logic                       i_sum_en,
    input  wire logic                       i_out_en,
    input  pts_pkg::t_s2                    i_s2,
    input  pts_pkg::t_cfg                   i_cfg,
    output logic [pts_pkg::PCT_W-1:0]       o_left_pct,
    output logic [pts_pkg::PCT_W-1:0]       o_right_pct,
    output logic [pts_pkg::ERR_W-1:0]       o_heading_error,
    output logic                            o_expired
);

    localparam int unsigned T = pts_pkg::TOTAL_W;
    localparam int unsigned Q = pts_pkg::QUOT_W;

    pts_pkg::t_s3              r_s3;
    logic [pts_pkg::PCT_W-1:0] r_left;
    logic [pts_pkg::PCT_W-1:0] r_right;
    logic [pts_pkg::ERR_W-1:0] r_err;
    logic                      r_expired;

    logic [T-1:0]              w_total;
    logic [Q-1:0]              w_quot;
    logic [Q-1:0]              w_lim;
    logic [Q-1:0]              w_neg_lim;
    logic [Q-1:0]              w_clamped;
    logic [pts_pkg::PCT_W-1:0] w_drive;

    // add the four products, high integral half weighted by 2^20
    always_comb begin
        w_total = {{(T - pts_pkg::PP_W){i_s2.pp[pts_pkg::PP_W-1]}}, i_s2.pp}
                + {{(T - pts_pkg::PD_W){i_s2.pd[pts_pkg::PD_W-1]}}, i_s2.pd}
                + {{(T - pts_pkg::PIL_W){i_s2.pil[pts_pkg::PIL_W-1]}}, i_s2.pil}
                + {{(T - pts_pkg::PIH_W - pts_pkg::SUM_LO_W){i_s2.pih[pts_pkg::PIH_W-1]}},
                   i_s2.pih, {pts_pkg::SUM_LO_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_sum_en) begin
            r_s3.kind  <= i_s2.kind;
            r_s3.err   <= i_s2.err;
            r_s3.total <= w_total;
        end
    end

    // scale by 2^-16 toward zero, clamp to the speed limit, and zero the drive unless running
    always_comb begin
        w_quot = r_s3.total[T-1:pts_pkg::SCALE_SH];
        if (r_s3.total[T-1] && (r_s3.total[pts_pkg::SCALE_SH-1:0] != '0)) begin
            w_quot = w_quot + Q'(1);
        end
        w_lim     = {{(Q - pts_pkg::LIMIT_W){1'b0}}, i_cfg.speed_limit};
        w_neg_lim = Q'(0) - w_lim;
        if ($signed(w_quot) > $signed(w_lim)) begin
            w_clamped = w_lim;
        end else if ($signed(w_quot) < $signed(w_neg_lim)) begin
            w_clamped = w_neg_lim;
        end else begin
            w_clamped = w_quot;
        end
        w_drive = (r_s3.kind == pts_pkg::KIND_RUN) ? w_clamped[pts_pkg::PCT_W-1:0] : '0;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_out_en) begin
            r_left    <= w_drive;
            r_right   <= pts_pkg::PCT_W'(0) - w_drive;
            r_err     <= r_s3.err;
            r_expired <= r_s3.kind == pts_pkg::KIND_EXPIRED;
        end
    end

    assign o_left_pct      = r_left;
    assign o_right_pct     = r_right;
    assign o_heading_error = r_err;
    assign o_expired       = r_expired;

endmodule

`default_nettype wire

// ===== design/pid_turn_step.sv =====
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+----------------------------------------
// in       | to block  | i_in_valid / o_in_stall | i_mode, i_measured_angle
// out      | from block| o_out_valid / i_out_stall | o_left_pct, o_right_pct,
//          |           |                         | o_heading_error, o_expired
// cfg      | to block  | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output does not stall; a taken word goes through
// the state update at the taking edge, then multipliers, final sum, scale/clamp into the
// result register. Loop state (last error, integral, tick count) is updated in the cycle
// a word is taken; a tick word past the timeout leaves it unchanged.
// Reset is synchronous and active low; it clears the valid bits, the loop state and
// sets the configuration registers to their defaults.
// A stall at the output fills the empty stages first; o_in_stall rises only once
// every stage holds a word.

module pid_turn_step (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_mode,
    input  wire logic [pts_pkg::ANGLE_W-1:0]       i_measured_angle,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [pts_pkg::PCT_W-1:0]              o_left_pct,
    output logic [pts_pkg::PCT_W-1:0]              o_right_pct,
    output logic [pts_pkg::ERR_W-1:0]              o_heading_error,
    output logic                                   o_expired,
    input  wire logic                              i_cfg_we,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    pts_pkg::t_cfg w_cfg;
    pts_pkg::t_s1  w_s1;
    pts_pkg::t_s2  w_s2;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_vo;
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdyo;
    logic w_accept;

    // advance a stage when it is empty or the next one advances
    assign w_rdyo   = !r_vo || !i_out_stall;
    assign w_rdy3   = !r_v3 || w_rdyo;
    assign w_rdy2   = !r_v2 || w_rdy3;
    assign w_rdy1   = !r_v1 || w_rdy2;
    assign w_accept = i_in_valid && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdyo) begin
                r_vo <= r_v3;
            end
        end
    end

    pts_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pts_track u_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_mode           (i_mode),
        .i_measured_angle (i_measured_angle),
        .i_cfg            (w_cfg),
        .o_s1             (w_s1)
    );

    pts_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_rdy2),
        .i_s1  (w_s1),
        .i_cfg (w_cfg),
        .o_s2  (w_s2)
    );

    pts_drive u_drive (
        .i_clk           (i_clk),
        .i_sum_en        (w_rdy3),
        .i_out_en        (w_rdyo),
        .i_s2            (w_s2),
        .i_cfg           (w_cfg),
        .o_left_pct      (o_left_pct),
        .o_right_pct     (o_right_pct),
        .o_heading_error (o_heading_error),
        .o_expired       (o_expired)
    );

    assign o_in_stall  = !w_rdy1;
    assign o_out_valid = r_vo;

endmodule

`default_nettype wire

// ===== design/pts_chk.sv =====
`default_nettype none

module pts_chk (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              o_in_stall,
    input  wire logic                              i_mode,
    input  wire logic [pts_pkg::ANGLE_W-1:0]       i_measured_angle,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic [pts_pkg::PCT_W-1:0]         o_left_pct,
    input  wire logic [pts_pkg::PCT_W-1:0]         o_right_pct,
    input  wire logic [pts_pkg::ERR_W-1:0]         o_heading_error,
    input  wire logic                              o_expired,
    input  wire logic                              i_cfg_we,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // right drive mirrors left drive
    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_right_pct == pts_pkg::PCT_W'(0) - o_left_pct))
        else $error("right drive is not the negation of left drive");

    // an expired word carries no drive
    a_expired_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_expired) |-> (o_left_pct == '0))
        else $error("expired word with nonzero drive");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_left_pct) && $stable(o_heading_error)
             && $stable(o_expired)))
        else $error("stalled result changed");

    // nothing valid right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind pid_turn_step pts_chk u_pts_chk (.*);

`default_nettype wire
